>>> rtl/core/dva_pkg.sv
// shared types, constants and calendar functions for the date check and add block
`timescale 1ns / 1ps

package dva_pkg;

  localparam int YEAR_BITS_DEF     = 16;
  localparam int ADD_DAYS_BITS_DEF = 16;

  localparam logic [8:0] YEAR_DAYS      = 9'd365;
  localparam logic [8:0] LEAP_YEAR_DAYS = 9'd366;
  localparam logic [9:0] CYCLE_YEARS    = 10'd400;
  localparam logic [8:0] CENTURY_1      = 9'd100;
  localparam logic [8:0] CENTURY_2      = 9'd200;
  localparam logic [8:0] CENTURY_3      = 9'd300;

  localparam logic [3:0] MONTH_JAN = 4'd1;
  localparam logic [3:0] MONTH_FEB = 4'd2;
  localparam logic [3:0] MONTH_DEC = 4'd12;
  localparam logic [4:0] DAY_LAST  = 5'd31;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic mod_step;
    logic mod_fix;
    logic check;
    logic doy;
    logic sum;
    logic year_step;
    logic month_step;
    logic out_load;
  } dva_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic year_fit;
    logic year_max;
    logic month_fit;
  } dva_sts_t;

  // leap test on the year taken mod 400
  function automatic logic leap_of_res(input logic [8:0] res);
    leap_of_res = (res[1:0] == 2'b00) && (res != CENTURY_1) &&
                  (res != CENTURY_2) && (res != CENTURY_3);
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: month_len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    month_len = 5'd30;
      4'd2:    month_len = leap ? 5'd29 : 5'd28;
      default: month_len = 5'd31;
    endcase
  endfunction

  // days before the first of month m in a common year
  function automatic logic [8:0] cum_days(input logic [3:0] m);
    case (m)
      4'd1:    cum_days = 9'd0;
      4'd2:    cum_days = 9'd31;
      4'd3:    cum_days = 9'd59;
      4'd4:    cum_days = 9'd90;
      4'd5:    cum_days = 9'd120;
      4'd6:    cum_days = 9'd151;
      4'd7:    cum_days = 9'd181;
      4'd8:    cum_days = 9'd212;
      4'd9:    cum_days = 9'd243;
      4'd10:   cum_days = 9'd273;
      4'd11:   cum_days = 9'd304;
      4'd12:   cum_days = 9'd334;
      default: cum_days = 9'd0;
    endcase
  endfunction

endpackage

>>> rtl/core/dva_ctrl.sv
// sequencing state machine for the date check and add block
`timescale 1ns / 1ps

module dva_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  dva_pkg::dva_sts_t sts,
  output dva_pkg::dva_cmd_t cmd
);
  import dva_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MOD, ST_FIX, ST_CHECK, ST_DOY, ST_SUM, ST_YEAR, ST_MONTH, ST_FIN
  } state_t;

  state_t           state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_busy;

  assign out_busy  = out_valid_r && out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MOD;
        end
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
        state_nxt    = ST_FIX;
      end
      ST_FIX: begin
        cmd.mod_fix = 1'b1;
        state_nxt   = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = ST_DOY;
      end
      ST_DOY: begin
        cmd.doy   = 1'b1;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = ST_YEAR;
      end
      ST_YEAR: begin
        cmd.year_step = 1'b1;
        if (sts.year_fit) begin
          state_nxt = ST_MONTH;
        end else if (sts.year_max) begin
          state_nxt = ST_FIN;
        end
      end
      ST_MONTH: begin
        cmd.month_step = 1'b1;
        if (sts.month_fit) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_busy) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/core/dva_dp.sv
// datapath: year residue, date check, day of year and the year and month walks
`timescale 1ns / 1ps

module dva_dp #(
  parameter int YEAR_BITS     = dva_pkg::YEAR_BITS_DEF,
  parameter int ADD_DAYS_BITS = dva_pkg::ADD_DAYS_BITS_DEF
) (
  input  logic                            clk,
  input  dva_pkg::dva_cmd_t               cmd,
  output dva_pkg::dva_sts_t               sts,
  input  logic [7:0]                      in_month_in,
  input  logic [7:0]                      in_day_in,
  input  logic signed [YEAR_BITS-1:0]     in_year_in,
  input  logic [ADD_DAYS_BITS-1:0]        in_add_days,
  output logic [3:0]                      out_month_out,
  output logic [4:0]                      out_day_out,
  output logic                            out_month_fixed,
  output logic                            out_day_fixed,
  output logic                            out_leap_year,
  output logic [8:0]                      out_day_of_year,
  output logic [8:0]                      out_days_left,
  output logic [3:0]                      out_new_month,
  output logic [4:0]                      out_new_day,
  output logic signed [YEAR_BITS-1:0]     out_new_year,
  output logic                            out_year_overflow
);
  import dva_pkg::*;

  localparam int REM_W = ((ADD_DAYS_BITS > 9) ? ADD_DAYS_BITS : 9) + 1;
  localparam logic [YEAR_BITS-1:0] YEAR_MAX = {1'b0, {(YEAR_BITS-1){1'b1}}};
  localparam logic [YEAR_BITS-1:0] YEAR_ONE = {{(YEAR_BITS-1){1'b0}}, 1'b1};
  // ceil(2^32 / 25), exact quotient for any dividend below 2^28
  localparam logic [27:0] RECIP_25 = 28'd171798692;

  logic [7:0]               month_raw_r, day_raw_r;
  logic [YEAR_BITS-1:0]     year_r, mag_r, ycur_r;
  logic [ADD_DAYS_BITS-1:0] add_r;
  logic [8:0]               res_r, doy_r;
  logic [3:0]               month_r, m_r, nm_r;
  logic [4:0]               day_r, nd_r, q5_r;
  logic                     mfix_r, dfix_r, leap_r, ovf_r;
  logic [REM_W-1:0]         rem_r;

  logic [27:0]      hi_w;
  logic [36:0]      prod_w;
  logic [4:0]       q25_w, rem25_w;
  logic [8:0]       res_pos_w;
  logic             mfix_w, dfix_w, leap_w, cur_leap;
  logic [3:0]       month_w;
  logic [4:0]       mlen_w, walk_len;
  logic [8:0]       ylen_cur, ylen_in;

  // |year| mod 400 = 16 * ((|year| >> 4) mod 25) + low nibble
  assign hi_w      = 28'(mag_r >> 4);
  // only the low quotient bits matter, so the product is kept to 37 bits
  assign prod_w    = 37'(hi_w) * 37'(RECIP_25);
  assign q25_w     = 5'(q5_r * 5'd25);
  assign rem25_w   = hi_w[4:0] - q25_w;
  assign res_pos_w = {rem25_w, mag_r[3:0]};

  assign leap_w   = leap_of_res(res_r);
  assign mfix_w   = (month_raw_r == 8'd0) || (month_raw_r > {4'd0, MONTH_DEC});
  assign month_w  = mfix_w ? MONTH_JAN : month_raw_r[3:0];
  assign mlen_w   = month_len(month_w, leap_w);
  assign dfix_w   = (day_raw_r == 8'd0) || (day_raw_r > {3'd0, mlen_w});

  // the walk tracks the residue of the current year, so leap comes from it
  assign cur_leap = leap_of_res(res_r);
  assign ylen_cur = cur_leap ? LEAP_YEAR_DAYS : YEAR_DAYS;
  assign walk_len = month_len(m_r, cur_leap);
  assign ylen_in  = leap_r ? LEAP_YEAR_DAYS : YEAR_DAYS;

  assign sts.year_fit  = (rem_r <= REM_W'(ylen_cur));
  assign sts.year_max  = (ycur_r == YEAR_MAX);
  assign sts.month_fit = (rem_r <= REM_W'(walk_len));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      month_raw_r <= in_month_in;
      day_raw_r   <= in_day_in;
      year_r      <= in_year_in;
      add_r       <= in_add_days;
      mag_r       <= in_year_in[YEAR_BITS-1] ? (~in_year_in + YEAR_ONE) : in_year_in;
      res_r       <= '0;
      ovf_r       <= 1'b0;
    end
    if (cmd.mod_step) begin
      q5_r <= prod_w[36:32];
    end
    if (cmd.mod_fix) begin
      if (year_r[YEAR_BITS-1] && (res_pos_w != 9'd0)) begin
        res_r <= 9'(CYCLE_YEARS - {1'b0, res_pos_w});
      end else begin
        res_r <= res_pos_w;
      end
    end
    if (cmd.check) begin
      leap_r  <= leap_w;
      mfix_r  <= mfix_w;
      dfix_r  <= dfix_w;
      month_r <= month_w;
      day_r   <= dfix_w ? 5'd1 : day_raw_r[4:0];
    end
    if (cmd.doy) begin
      doy_r  <= cum_days(month_r) + {8'd0, leap_r && (month_r > MONTH_FEB)} + {4'd0, day_r};
      ycur_r <= year_r;
      m_r    <= MONTH_JAN;
    end
    if (cmd.sum) begin
      rem_r <= REM_W'(doy_r) + REM_W'(add_r);
    end
    if (cmd.year_step && !sts.year_fit) begin
      if (sts.year_max) begin
        ovf_r <= 1'b1;
      end else begin
        rem_r  <= rem_r - REM_W'(ylen_cur);
        ycur_r <= ycur_r + YEAR_ONE;
        res_r  <= (res_r == 9'(CYCLE_YEARS - 10'd1)) ? 9'd0 : res_r + 9'd1;
      end
    end
    if (cmd.month_step) begin
      if (sts.month_fit) begin
        nm_r <= m_r;
        nd_r <= rem_r[4:0];
      end else begin
        rem_r <= rem_r - REM_W'(walk_len);
        m_r   <= m_r + 4'd1;
      end
    end
    if (cmd.out_load) begin
      out_month_out     <= month_r;
      out_day_out       <= day_r;
      out_month_fixed   <= mfix_r;
      out_day_fixed     <= dfix_r;
      out_leap_year     <= leap_r;
      out_day_of_year   <= doy_r;
      out_days_left     <= ylen_in - doy_r;
      out_new_month     <= ovf_r ? MONTH_DEC : nm_r;
      out_new_day       <= ovf_r ? DAY_LAST : nd_r;
      out_new_year      <= ycur_r;
      out_year_overflow <= ovf_r;
    end
  end

endmodule

>>> rtl/core/date_validate_and_add_days_top.sv
// top level of the gregorian date check and add-days block
`timescale 1ns / 1ps

// Checks a raw month/day/year and adds a day count to it, one transfer in and
// one transfer out per item. A month outside 1..12 or a day outside the month
// is replaced by 1 and flagged; the Gregorian leap rule applies, negative years
// included. After the check the year walk subtracts one year per cycle until the
// remaining days fit in the current year, and the month walk then steps up to 11
// months in the final year; an item that overflows skips the month walk. At
// 16-bit day counts the number of year boundaries crossed stays near 180. The
// mod-400 residue of the year is found in the states ST_MOD and ST_FIX
// (reciprocal multiply, then fold and sign fix). One item is worked at a time
// and the next can be taken in the cycle after the result load. The finished
// result sits in an output register, so a new item is taken while the previous
// result still waits on out_stall. If the walk would pass the largest year the
// result saturates to December 31 of that year and out_year_overflow is set.
module date_validate_and_add_days_top #(
  parameter int YEAR_BITS     = dva_pkg::YEAR_BITS_DEF,
  parameter int ADD_DAYS_BITS = dva_pkg::ADD_DAYS_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [7:0]                  in_month_in,
  input  logic [7:0]                  in_day_in,
  input  logic signed [YEAR_BITS-1:0] in_year_in,
  input  logic [ADD_DAYS_BITS-1:0]    in_add_days,
  // result channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [3:0]                  out_month_out,
  output logic [4:0]                  out_day_out,
  output logic                        out_month_fixed,
  output logic                        out_day_fixed,
  output logic                        out_leap_year,
  output logic [8:0]                  out_day_of_year,
  output logic [8:0]                  out_days_left,
  output logic [3:0]                  out_new_month,
  output logic [4:0]                  out_new_day,
  output logic signed [YEAR_BITS-1:0] out_new_year,
  output logic                        out_year_overflow
);
  import dva_pkg::*;

  dva_cmd_t cmd;
  dva_sts_t sts;

  // sequencer: accept, residue, check, day of year, sum, year walk, month walk, result load
  dva_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // all arithmetic and the output register
  dva_dp #(
    .YEAR_BITS    (YEAR_BITS),
    .ADD_DAYS_BITS(ADD_DAYS_BITS)
  ) u_dp (
    .clk              (clk),
    .cmd              (cmd),
    .sts              (sts),
    .in_month_in      (in_month_in),
    .in_day_in        (in_day_in),
    .in_year_in       (in_year_in),
    .in_add_days      (in_add_days),
    .out_month_out    (out_month_out),
    .out_day_out      (out_day_out),
    .out_month_fixed  (out_month_fixed),
    .out_day_fixed    (out_day_fixed),
    .out_leap_year    (out_leap_year),
    .out_day_of_year  (out_day_of_year),
    .out_days_left    (out_days_left),
    .out_new_month    (out_new_month),
    .out_new_day      (out_new_day),
    .out_new_year     (out_new_year),
    .out_year_overflow(out_year_overflow)
  );

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !(out_valid && out_stall))
    else $error("result register loaded while a result is still pending");

  // an accepted transfer starts the residue pass in the next cycle
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (cmd.mod_step && in_stall))
    else $error("accepted item did not start processing");

  // loading the result register raises valid
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid)
    else $error("result loaded without valid");

  // result months always legal
  a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_new_month >= MONTH_JAN) && (out_new_month <= MONTH_DEC) &&
                  (out_month_out >= MONTH_JAN) && (out_month_out <= MONTH_DEC))
    else $error("result month out of range");

endmodule
